### hdl/dbd_pkg.sv
// Package with shared types, constants and the sigmoid table builder for the box decoder.
package dbd_pkg;

	// Field widths.
	localparam int IDX_W   = 10;
	localparam int LOGIT_W = 16;
	localparam int FRAC_W  = 16;
	localparam int SIZE_W  = 14;
	localparam int PIX_W   = 13;
	localparam int THR_W   = 17;

	// Sigmoid lookup table geometry.
	localparam int SIG_ENTRIES = 1024;
	localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);

	// Queries at or above this index are never reported.
	localparam logic [THR_W-1:0] MAX_QUERIES = 17'd1024;

	// Register map, indexed by word address.
	localparam int CFG_ADDR_W = 4;
	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_SCORE_THRESHOLD = 2'd2,
		REG_UNUSED          = 2'd3
	} reg_idx_t;

	// Reset values of the registers.
	localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = 14'd640;
	localparam logic [THR_W-1:0]  THRESHOLD_RST  = 17'd32768;
	localparam logic [SIZE_W-1:0] SIZE_MAX       = 14'd8192;

	// Register contents as seen by the datapath (sizes already clamped).
	typedef struct packed {
		logic [SIZE_W-1:0] eff_w;
		logic [SIZE_W-1:0] eff_h;
		logic [THR_W-1:0]  threshold;
	} cfg_t;

	// Per-stage load enables of the pipeline.
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic ld4;
	} pipe_ctl_t;

	typedef logic [SIG_ENTRIES-1:0][FRAC_W-1:0] sig_table_t;

	// Unsigned 64-bit quotient by shift and subtract, used only while the
	// table is built at elaboration.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, dvs}) begin
				rem    = rem - {1'b0, dvs};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Builds the sigmoid table at elaboration. Entry k holds the sigmoid of the
	// midpoint of the logit bin it covers, computed from a Q0.31 series for
	// exp(-1/128) and its rounded powers.
	function automatic sig_table_t build_sig_table();
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] c31;
		logic [63:0] p;
		logic [63:0] den;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [SIG_IDX_W-1:0] hi;
		sig_table_t t;
		t    = '0;
		term = 64'd1 << 62;
		sum  = term;
		p    = 64'd1 << 31;
		for (int n = 1; n < 12; n++) begin
			term = udiv64(term, 64'd128 * 64'(n));
			if (n[0] == 1'b1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		c31 = (sum + (64'd1 << 30)) >> 31;
		for (int j = 1; j < SIG_ENTRIES; j++) begin
			p = (p * c31 + (64'd1 << 30)) >> 31;
			if (j[0] == 1'b1) begin
				hi  = SIG_IDX_W'((SIG_ENTRIES >> 1) + ((j - 1) >> 1));
				den = (64'd1 << 31) + p;
				pos = udiv64((64'd1 << 47) + (den >> 1), den);
				neg = udiv64((p << 16) + (den >> 1), den);
				if (pos > 64'd65535) begin
					pos = 64'd65535;
				end
				if (neg > 64'd65535) begin
					neg = 64'd65535;
				end
				t[hi]  = pos[FRAC_W-1:0];
				t[~hi] = neg[FRAC_W-1:0];
			end
		end
		return t;
	endfunction

endpackage

### hdl/dbd_ifs.sv
// Stream interfaces for detection queries and decoded detections.

interface dbd_query_if;
	logic               valid;
	logic               ready;
	logic [9:0]         query_index;
	logic signed [15:0] score_logit;
	logic [15:0]        center_x;
	logic [15:0]        center_y;
	logic [15:0]        size_w;
	logic [15:0]        size_h;

	modport source (
		output valid, query_index, score_logit, center_x, center_y, size_w, size_h,
		input  ready
	);
	modport sink (
		input  valid, query_index, score_logit, center_x, center_y, size_w, size_h,
		output ready
	);
endinterface

interface dbd_det_if;
	logic        valid;
	logic        ready;
	logic [9:0]  kept_index;
	logic [15:0] score_value;
	logic [12:0] left_edge;
	logic [12:0] top_edge;
	logic [12:0] rect_width;
	logic [12:0] rect_height;

	modport source (
		output valid, kept_index, score_value, left_edge, top_edge, rect_width, rect_height,
		input  ready
	);
	modport sink (
		input  valid, kept_index, score_value, left_edge, top_edge, rect_width, rect_height,
		output ready
	);
endinterface

### hdl/dbd_cfg.sv
// APB register block holding image size and score threshold.
module dbd_cfg
	import dbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [THR_W-1:0]  thresh_q;
	logic [SIZE_W-1:0] eff_w_q;
	logic [SIZE_W-1:0] eff_h_q;
	logic              wr_en;
	reg_idx_t          widx;

	// A zero size acts as one pixel, anything past the maximum as the maximum.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > SIZE_MAX) begin
			r = SIZE_MAX;
		end
		return r;
	endfunction

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign widx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	// Register writes; the clamped sizes are kept next to the raw values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_SIZE_RST;
			height_q <= IMAGE_SIZE_RST;
			thresh_q <= THRESHOLD_RST;
			eff_w_q  <= IMAGE_SIZE_RST;
			eff_h_q  <= IMAGE_SIZE_RST;
		end else if (wr_en) begin
			unique case (widx)
				REG_IMAGE_WIDTH: begin
					width_q <= pwdata[SIZE_W-1:0];
					eff_w_q <= clamp_size(pwdata[SIZE_W-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[SIZE_W-1:0];
					eff_h_q  <= clamp_size(pwdata[SIZE_W-1:0]);
				end
				REG_SCORE_THRESHOLD: begin
					thresh_q <= pwdata[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back the raw register values.
	always_comb begin
		unique case (widx)
			REG_IMAGE_WIDTH:     prdata = {{(32-SIZE_W){1'b0}}, width_q};
			REG_IMAGE_HEIGHT:    prdata = {{(32-SIZE_W){1'b0}}, height_q};
			REG_SCORE_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, thresh_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.eff_w     = eff_w_q;
	assign cfg.eff_h     = eff_h_q;
	assign cfg.threshold = thresh_q;

endmodule

### hdl/dbd_score.sv
// Sigmoid lookup of the score logit, registered into the first pipeline stage.
module dbd_score
	import dbd_pkg::*;
(
	input  logic                      clk,
	input  pipe_ctl_t                 ctl,
	input  logic signed [LOGIT_W-1:0] logit,
	output logic [FRAC_W-1:0]         score_s1
);

	localparam sig_table_t SIG_TABLE = build_sig_table();

	logic [SIG_IDX_W-1:0] sig_idx;

	// Offset the logit by 8.0 and keep the top bits: bins of 1/64.
	assign sig_idx = {~logit[LOGIT_W-1], logit[LOGIT_W-2:LOGIT_W-SIG_IDX_W]};

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			score_s1 <= SIG_TABLE[sig_idx];
		end
	end

endmodule

### hdl/dbd_axis.sv
// Three-stage decode of one box axis: scale, form corners, clamp and measure.
module dbd_axis
	import dbd_pkg::*;
(
	input  logic              clk,
	input  pipe_ctl_t         ctl,
	input  logic [FRAC_W-1:0] center,
	input  logic [FRAC_W-1:0] extent,
	input  logic [SIZE_W-1:0] size,
	output logic [PIX_W-1:0]  lo_s4,
	output logic [PIX_W-1:0]  ext_s4
);

	localparam int PROD_W = FRAC_W + PIX_W;

	logic [PROD_W:0]        twice_s2;
	logic [PROD_W-1:0]      span_s2;
	logic signed [PROD_W+2:0] low2;
	logic [PROD_W+1:0]      high2;
	logic [PIX_W-1:0]       lo_s3;
	logic [SIZE_W-1:0]      hraw_s3;
	logic [SIZE_W-1:0]      size_m1;
	logic [SIZE_W-1:0]      hclamp;
	logic [SIZE_W-1:0]      hfin;
	logic [SIZE_W-1:0]      lo_ext;

	// Stage 2: scale centre and extent to pixels (times two for the centre).
	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			twice_s2 <= {PROD_W'(center * size), 1'b0};
			span_s2  <= PROD_W'(extent * size);
		end
	end

	// Stage 3: corner sums in 1/2^17 pixel units, then floor.
	assign low2  = $signed({2'b00, twice_s2}) - $signed({3'b000, span_s2});
	assign high2 = {1'b0, twice_s2} + {2'b00, span_s2};

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			lo_s3   <= (low2 > 0) ? low2[PROD_W:PROD_W-PIX_W+1] : '0;
			hraw_s3 <= high2[PROD_W+1:PROD_W+2-SIZE_W];
		end
	end

	// Stage 4: clamp the far edge into the image and never below the near edge.
	assign size_m1 = size - SIZE_W'(1);
	assign lo_ext  = {1'b0, lo_s3};
	assign hclamp  = (hraw_s3 > size_m1) ? size_m1 : hraw_s3;
	assign hfin    = (hclamp < lo_ext) ? lo_ext : hclamp;

	always_ff @(posedge clk) begin
		if (ctl.ld4) begin
			lo_s4  <= lo_s3;
			ext_s4 <= PIX_W'(hfin - lo_ext);
		end
	end

endmodule

### hdl/detection_box_decode.sv
// Top level of the detection box decoder: sigmoid score, threshold and pixel box.
//
//   port      | dir | kind          | carries
//   ----------+-----+---------------+------------------------------------------
//   query     | in  | valid/ready   | query index, score logit, centre and size
//   det       | out | valid/ready   | kept index, score, left, top, width, height
//   APB       | in  | psel/penable  | image width, image height, score threshold
//
// One query is taken per cycle unless every stage is full and det stalls; a kept one
// passes stages 1 to 4 in turn and is presented on det from the stage 4 registers.
// The depth is set by the table read, the scaling multipliers,
// the corner adders and the clamp stage. Dropped queries leave a bubble only.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage holds while the one after it is full and stalled, so bubbles
// are squeezed out and input is still taken while a result waits on det.
module detection_box_decode
	import dbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	dbd_query_if.sink             query,
	dbd_det_if.source             det
);

	cfg_t              cfg;
	pipe_ctl_t         ctl;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic              rdy1, rdy2, rdy3, rdy4;
	logic              keep_s1;
	logic [IDX_W-1:0]  qi_s1, qi_s2, qi_s3, qi_s4;
	logic [FRAC_W-1:0] score_s1, score_s2, score_s3, score_s4;
	logic [FRAC_W-1:0] cx_s1, cy_s1, sw_s1, sh_s1;

	dbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A stage takes new data when it is empty or the next one moves.
	assign rdy4 = !v_s4 || det.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign query.ready = rdy1;

	assign ctl.ld1 = rdy1;
	assign ctl.ld2 = rdy2;
	assign ctl.ld3 = rdy3;
	assign ctl.ld4 = rdy4;

	// Threshold and index range decide whether the query survives past stage 1.
	assign keep_s1 = ({1'b0, score_s1} >= cfg.threshold) &&
		({{(THR_W-IDX_W){1'b0}}, qi_s1} < MAX_QUERIES);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= query.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1 && keep_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Index, score and box fields riding along the stages.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			qi_s1 <= query.query_index;
			cx_s1 <= query.center_x;
			cy_s1 <= query.center_y;
			sw_s1 <= query.size_w;
			sh_s1 <= query.size_h;
		end
		if (rdy2) begin
			qi_s2    <= qi_s1;
			score_s2 <= score_s1;
		end
		if (rdy3) begin
			qi_s3    <= qi_s2;
			score_s3 <= score_s2;
		end
		if (rdy4) begin
			qi_s4    <= qi_s3;
			score_s4 <= score_s3;
		end
	end

	dbd_score u_score (
		.clk      (clk),
		.ctl      (ctl),
		.logit    (query.score_logit),
		.score_s1 (score_s1)
	);

	dbd_axis u_axis_x (
		.clk    (clk),
		.ctl    (ctl),
		.center (cx_s1),
		.extent (sw_s1),
		.size   (cfg.eff_w),
		.lo_s4  (det.left_edge),
		.ext_s4 (det.rect_width)
	);

	dbd_axis u_axis_y (
		.clk    (clk),
		.ctl    (ctl),
		.center (cy_s1),
		.extent (sh_s1),
		.size   (cfg.eff_h),
		.lo_s4  (det.top_edge),
		.ext_s4 (det.rect_height)
	);

	assign det.valid       = v_s4;
	assign det.kept_index  = qi_s4;
	assign det.score_value = score_s4;

	// A query that fails the threshold or index test never enters stage 2.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy2 && v_s1 && !keep_s1) |=> !v_s2)
		else $error("dropped query reached stage 2");

	// Input is held off only when every stage is full and the output stalls.
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !det.ready))
		else $error("input stalled while the pipeline has room");

	// A reported score always meets the threshold.
	a_score_kept: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid |-> ({1'b0, det.score_value} >= cfg.threshold))
		else $error("reported score below threshold");

	// The box always lies inside the image.
	a_box_inside: assert property (@(posedge clk) disable iff (!arst_n)
		det.valid |-> ((({1'b0, det.left_edge} + {1'b0, det.rect_width}) < cfg.eff_w) &&
			(({1'b0, det.top_edge} + {1'b0, det.rect_height}) < cfg.eff_h)))
		else $error("box extends past the image");

endmodule

### tb/sv/tb_detection_box_decode.sv
`timescale 1ns / 1ps
// Self-checking testbench for the detection box decoder: query stream in, decoded boxes out.
module tb_detection_box_decode;
	import dbd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [IDX_W-1:0]          idx;
		logic signed [LOGIT_W-1:0] logit;
		logic [FRAC_W-1:0]         cx;
		logic [FRAC_W-1:0]         cy;
		logic [FRAC_W-1:0]         sw;
		logic [FRAC_W-1:0]         sh;
	} query_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [FRAC_W-1:0] score;
		logic [PIX_W-1:0]  left_px;
		logic [PIX_W-1:0]  top_px;
		logic [PIX_W-1:0]  ext_w;
		logic [PIX_W-1:0]  ext_h;
	} det_t;

	// Scoreboard: holds its own copy of the registers and the sigmoid table and
	// keeps the boxes that accepted queries should produce, oldest first.
	class box_scoreboard;
		logic [FRAC_W-1:0] sig_lut [SIG_ENTRIES];
		logic [SIZE_W-1:0] width_reg;
		logic [SIZE_W-1:0] height_reg;
		logic [THR_W-1:0]  thr_reg;
		det_t              box_queue[$];
		int                mismatches;
		int                queries;
		int                kept;
		int                dropped;
		int                checked;

		function new();
			width_reg  = 14'd640;
			height_reg = 14'd640;
			thr_reg    = 17'd32768;
			mismatches = 0;
			queries    = 0;
			kept       = 0;
			dropped    = 0;
			checked    = 0;
			fill_sigmoid();
		endfunction

		// Sigmoid of each bin midpoint, from exp(-1/128) in Q0.31 and its
		// rounded powers. Odd powers land on the bin midpoints.
		function void fill_sigmoid();
			logic [63:0] term;
			logic [63:0] acc;
			logic [63:0] step;
			logic [63:0] pw;
			logic [63:0] den;
			logic [63:0] up;
			logic [63:0] dn;
			int          mid;
			term = 64'd1 << 62;
			acc  = term;
			pw   = 64'd1 << 31;
			for (int n = 1; n < 12; n++) begin
				term = term / (64'd128 * 64'(n));
				if (n % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			step = (acc + (64'd1 << 30)) >> 31;
			for (int j = 1; j < SIG_ENTRIES; j++) begin
				pw = (pw * step + (64'd1 << 30)) >> 31;
				if (j % 2 == 1) begin
					mid = SIG_ENTRIES / 2 + (j - 1) / 2;
					den = (64'd1 << 31) + pw;
					up  = ((64'd1 << 47) + den / 64'd2) / den;
					dn  = ((pw << 16) + den / 64'd2) / den;
					if (up > 64'd65535) begin
						up = 64'd65535;
					end
					if (dn > 64'd65535) begin
						dn = 64'd65535;
					end
					sig_lut[mid] = up[FRAC_W-1:0];
					sig_lut[SIG_ENTRIES - 1 - mid] = dn[FRAC_W-1:0];
				end
			end
		endfunction

		function void write_reg(reg_idx_t r, logic [31:0] v);
			case (r)
				REG_IMAGE_WIDTH: begin
					width_reg = v[SIZE_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = v[SIZE_W-1:0];
				end
				REG_SCORE_THRESHOLD: begin
					thr_reg = v[THR_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// A size register of zero acts as one pixel, anything above 8192 as 8192.
		function longint pixel_size(logic [SIZE_W-1:0] r);
			if (r == 0) begin
				return 1;
			end
			if (r > 14'd8192) begin
				return 8192;
			end
			return longint'(r);
		endfunction

		// Corners along one axis in doubled fixed point, floored and clamped.
		function void decode_axis(input logic [FRAC_W-1:0] c, input logic [FRAC_W-1:0] s,
				input longint size, output logic [PIX_W-1:0] lo, output logic [PIX_W-1:0] ext);
			longint twice_c;
			longint span;
			longint low2;
			longint high2;
			longint l;
			longint hgh;
			longint e;
			twice_c = 2 * longint'(c) * size;
			span    = longint'(s) * size;
			low2    = twice_c - span;
			high2   = twice_c + span;
			l       = 0;
			hgh     = high2 >>> 17;
			if (low2 > 0) begin
				l = low2 >>> 17;
			end
			if (hgh > size - 1) begin
				hgh = size - 1;
			end
			if (hgh < l) begin
				hgh = l;
			end
			e   = hgh - l;
			lo  = l[PIX_W-1:0];
			ext = e[PIX_W-1:0];
		endfunction

		function void note_query(query_t q);
			logic [SIG_IDX_W-1:0] bin;
			logic [FRAC_W-1:0]    s;
			logic [PIX_W-1:0]     lo;
			logic [PIX_W-1:0]     ext;
			det_t                 want;
			queries++;
			// Offset the logit by 8.0 and keep the top ten bits as the table index.
			bin = {~q.logit[LOGIT_W-1], q.logit[LOGIT_W-2:6]};
			s   = sig_lut[bin];
			if ({1'b0, s} < thr_reg) begin
				dropped++;
				return;
			end
			want.idx   = q.idx;
			want.score = s;
			decode_axis(q.cx, q.sw, pixel_size(width_reg), lo, ext);
			want.left_px = lo;
			want.ext_w   = ext;
			decode_axis(q.cy, q.sh, pixel_size(height_reg), lo, ext);
			want.top_px = lo;
			want.ext_h  = ext;
			box_queue = {box_queue, want};
			kept++;
		endfunction

		function void check_det(det_t got);
			det_t want;
			bit   bad;
			checked++;
			if (box_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected detection: idx=%0d score=%0d box=(%0d,%0d,%0d,%0d)",
						got.idx, got.score, got.left_px, got.top_px, got.ext_w, got.ext_h);
				end
				return;
			end
			want = box_queue.pop_front();
			bad = (got.idx != want.idx) || (got.score != want.score) ||
				(got.left_px != want.left_px) || (got.top_px != want.top_px) ||
				(got.ext_w != want.ext_w) || (got.ext_h != want.ext_h);
			if (bad) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("detection mismatch: expected idx=%0d score=%0d box=(%0d,%0d,%0d,%0d)",
						want.idx, want.score, want.left_px, want.top_px, want.ext_w, want.ext_h);
					$display("                    actual   idx=%0d score=%0d box=(%0d,%0d,%0d,%0d)",
						got.idx, got.score, got.left_px, got.top_px, got.ext_w, got.ext_h);
				end
			end
		endfunction

		function int pending();
			return box_queue.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	dbd_query_if qif ();
	dbd_det_if   dif ();

	box_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int settings_run   = 0;

	detection_box_decode uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.query   (qif),
		.det     (dif)
	);

	always #6 clk = ~clk;

	// Run length guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d boxes still owed", cycle_count, sb.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Beat monitor on both streams.
	always @(posedge clk) begin
		if (arst_n) begin
			if (qif.valid && qif.ready) begin
				sb.note_query('{qif.query_index, qif.score_logit, qif.center_x, qif.center_y,
					qif.size_w, qif.size_h});
			end
			if (dif.valid && dif.ready) begin
				sb.check_det('{dif.kept_index, dif.score_value, dif.left_edge, dif.top_edge,
					dif.rect_width, dif.rect_height});
			end
		end
	end

	// Output side ready: a long hold-off when requested, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			dif.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			dif.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic query_t mk_query(int idx, int logit, int cx, int cy, int sw, int sh);
		query_t q;
		q.idx   = idx[IDX_W-1:0];
		q.logit = logit[LOGIT_W-1:0];
		q.cx    = cx[FRAC_W-1:0];
		q.cy    = cy[FRAC_W-1:0];
		q.sw    = sw[FRAC_W-1:0];
		q.sh    = sh[FRAC_W-1:0];
		return q;
	endfunction

	// Fractions lean toward the edges of the range so clamps get exercised.
	function automatic int rand_frac();
		case ($urandom_range(7))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(255);
			3: return 65535 - $urandom_range(255);
			default: return $urandom_range(65535);
		endcase
	endfunction

	function automatic query_t rand_query();
		int logit;
		case ($urandom_range(9))
			0: logit = ($urandom_range(1) != 0) ? 32767 : -32768;
			1, 2: logit = $urandom_range(8191) - 4096;
			default: logit = $urandom_range(65535);
		endcase
		return mk_query($urandom_range(1023), logit, rand_frac(), rand_frac(),
			rand_frac(), rand_frac());
	endfunction

	// Present one query beat and wait for it to be taken.
	task automatic offer_query(input query_t q);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			qif.valid <= 1'b0;
			@(negedge clk);
		end
		qif.valid       <= 1'b1;
		qif.query_index <= q.idx;
		qif.score_logit <= q.logit;
		qif.center_x    <= q.cx;
		qif.center_y    <= q.cy;
		qif.size_w      <= q.sw;
		qif.size_h      <= q.sh;
		@(posedge clk);
		while (!qif.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic stop_queries();
		@(negedge clk);
		qif.valid <= 1'b0;
	endtask

	// Wait until every owed box is out, then let dropped queries clear the pipe.
	task automatic settle();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup phase, then access phase until pready.
	task automatic write_register(input reg_idx_t r, input logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		sb.write_reg(r, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_image(input int w, input int h, input int thr);
		stop_queries();
		settle();
		write_register(REG_IMAGE_WIDTH, w);
		write_register(REG_IMAGE_HEIGHT, h);
		write_register(REG_SCORE_THRESHOLD, thr);
		settings_run++;
	endtask

	task automatic random_queries(input int n);
		for (int i = 0; i < n; i++) begin
			offer_query(rand_query());
		end
	endtask

	// Main sequence.
	initial begin
		int w;
		int h;
		int thr;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		qif.valid       = 1'b0;
		qif.query_index = '0;
		qif.score_logit = '0;
		qif.center_x    = '0;
		qif.center_y    = '0;
		qif.size_w      = '0;
		qif.size_h      = '0;
		dif.ready       = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset registers, scores on both sides of one half.
		offer_query(mk_query(0, 0, 32768, 32768, 16384, 16384));
		offer_query(mk_query(1, -1, 32768, 32768, 16384, 16384));
		offer_query(mk_query(1023, 32767, 0, 0, 65535, 65535));
		offer_query(mk_query(2, -32768, 1000, 2000, 3000, 4000));
		offer_query(mk_query(1023, 32767, 65535, 65535, 65535, 65535));
		offer_query(mk_query(3, 4096, 12345, 54321, 0, 0));
		offer_query(mk_query(512, 64, 0, 65535, 0, 65535));

		// Threshold zero keeps everything; zero-sized image acts as one pixel.
		set_image(0, 0, 0);
		offer_query(mk_query(0, -32768, 0, 0, 0, 0));
		offer_query(mk_query(1023, 32767, 65535, 65535, 65535, 65535));
		offer_query(mk_query(5, -20000, 32768, 32768, 65535, 0));

		// Largest images, including an oversized width register.
		set_image(16383, 8192, 1);
		offer_query(mk_query(7, 32767, 65535, 65535, 65535, 65535));
		offer_query(mk_query(8, 32767, 0, 0, 65535, 65535));
		offer_query(mk_query(9, 8000, 65535, 0, 2, 2));
		offer_query(mk_query(10, 8000, 1, 65534, 65535, 1));

		// Threshold above every score drops all queries.
		set_image(1920, 1080, 65536);
		offer_query(mk_query(11, 32767, 32768, 32768, 16384, 16384));
		offer_query(mk_query(12, 0, 32768, 32768, 16384, 16384));
		set_image(1920, 1080, 131071);
		offer_query(mk_query(13, 32767, 32768, 32768, 16384, 16384));

		// Random phases, rotating through the idling modes.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin w = 640;  h = 480;   thr = 32768; end
				1: begin w = 1;    h = 8192;  thr = 0; end
				2: begin w = 8192; h = 1;     thr = 40000; end
				3: begin w = 0;    h = 16383; thr = 20000; end
				6: begin w = 8192; h = 8192;  thr = 65535; end
				7: begin w = 1280; h = 720;   thr = 131071; end
				default: begin
					w   = $urandom_range(8192, 1);
					h   = $urandom_range(8192, 1);
					thr = $urandom_range(65535);
				end
			endcase
			set_image(w, h, thr);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			random_queries(84);
		end

		// Backpressure: output held off while queries keep coming at full rate.
		set_image(1024, 768, 8192);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 300;
		random_queries(60);

		stop_queries();
		settle();

		$display("Ran %0d queries across %0d register settings and four idling modes.",
			sb.queries, settings_run + 1);
		$display("Checked %0d detections, %0d queries dropped by threshold, %0d mismatches.",
			sb.checked, sb.dropped, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (sb.pending() != 0) begin
				$display("%0d expected detections never arrived", sb.pending());
			end
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### detection_box_decode.f
hdl/dbd_pkg.sv
hdl/dbd_ifs.sv
hdl/dbd_cfg.sv
hdl/dbd_score.sv
hdl/dbd_axis.sv
hdl/detection_box_decode.sv
tb/sv/tb_detection_box_decode.sv
